// ----- hdl/dep_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dep_pkg: shared types and constants for the direction to pixel block
// Holds the CORDIC step angle table and the cell data record.
// ----------------------------------------------------------------------------
package dep_pkg;
	localparam int AtanLen = 30;
	localparam int DirW = 16;
	localparam int VecW = 28; // scaled components and square root stay below 2^26
	localparam int WidthW = 14;
	localparam int HeightW = 13;
	localparam int RowW = 12;
	localparam int ColW = 13;
	localparam logic [0:0] RegWidth = 1'b0;
	localparam logic [0:0] RegHeight = 1'b1;

	function automatic logic [31:0] atan_turns(input int i);
		logic [31:0] t;
		begin
			case (i)
				0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
				3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
				6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
				9: t = 32'h00145F2E;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
				12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
				15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
				18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
				21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
				24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
				27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
				default: t = 32'h0;
			endcase
			return t;
		end
	endfunction

	// step angle rounded half up to ab bits
	function automatic logic [32:0] step_angle(input int i, input int ab);
		logic [32:0] w;
		begin
			w = {atan_turns(i), 1'b0} >> (32 - ab);
			return (w + 33'd1) >> 1;
		end
	endfunction

	// sideband that travels with an item
	typedef struct packed {
		logic             degen;
		logic             zero_vec;
		logic             back;
		logic [WidthW-1:0]  width;
		logic [HeightW-1:0] height;
	} side_t;
endpackage

// ----- hdl/dep_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dep_dir_if / dep_pix_if: valid-ready channels
// Direction items in, pixel items out.
// ----------------------------------------------------------------------------
interface dep_dir_if;
	logic valid;
	logic ready;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	modport source (output valid, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface dep_pix_if;
	logic valid;
	logic ready;
	logic [11:0] pixel_row;
	logic [12:0] pixel_column;
	logic degenerate;
	modport source (output valid, pixel_row, pixel_column, degenerate, input ready);
	modport sink (input valid, pixel_row, pixel_column, degenerate, output ready);
endinterface

// ----- hdl/dep_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dep_sqrt_cell: one digit of a restoring square root
// Settles one result bit of the horizontal length per cycle when en is high.
// ----------------------------------------------------------------------------
module dep_sqrt_cell #(
	parameter int K = 0,
	parameter int W = 50
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] rem_i,
	input  logic [W-1:0] res_i,
	output logic [W-1:0] rem_q,
	output logic [W-1:0] res_q
);
	logic [W-1:0] bit_w;
	logic [W-1:0] trial;
	assign bit_w = W'(1) << (2 * K);
	assign trial = res_i + bit_w;
	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_i >= trial) begin
				rem_q <= rem_i - trial;
				res_q <= (res_i >> 1) + bit_w;
			end else begin
				rem_q <= rem_i;
				res_q <= res_i >> 1;
			end
		end
	end
endmodule

// ----- hdl/dep_cordic_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dep_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward the positive first axis and accumulates the angle.
// ----------------------------------------------------------------------------
module dep_cordic_cell #(
	parameter int I = 0,
	parameter int AW = 24,
	parameter int VW = 28
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [VW-1:0] a_i,
	input  logic signed [VW-1:0] b_i,
	input  logic signed [AW:0]   ang_i,
	output logic signed [VW-1:0] a_q,
	output logic signed [VW-1:0] b_q,
	output logic signed [AW:0]   ang_q
);
	import dep_pkg::*;
	localparam logic [32:0] StepW = step_angle(I, AW);
	localparam logic signed [AW:0] Step = (AW + 1)'(StepW);
	always_ff @(posedge clk) begin
		if (en) begin
			if (!b_i[VW-1]) begin
				a_q <= a_i + (b_i >>> I);
				b_q <= b_i - (a_i >>> I);
				ang_q <= ang_i + Step;
			end else begin
				a_q <= a_i - (b_i >>> I);
				b_q <= b_i + (a_i >>> I);
				ang_q <= ang_i - Step;
			end
		end
	end
endmodule

// ----- hdl/direction_to_equirect_pixel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_to_equirect_pixel: direction vector to equirectangular pixel
// Longitude and latitude by chains of CORDIC cells, then scale to row/column.
// ----------------------------------------------------------------------------
// channel  dir  payload
// din      in   dir_x, dir_y, dir_z (signed Q1.15)
// dout     out  pixel_row, pixel_column, degenerate
// cfg      in   cfg_we, cfg_index, cfg_data (width, height)
//
// One item per cycle sustained while the output is not stalled. The pipeline
// is 1 input stage, 25 square root cells, the CORDIC steps and 3 scaling
// stages. The whole chain advances as one when the output register is free or
// taken; a stalled output holds every stage. Reset clears the valid bits and
// sets the two image registers to 4096 by 2048.
// ----------------------------------------------------------------------------
module direction_to_equirect_pixel #(
	parameter int ANGLE_BITS = 24,
	parameter int CORDIC_STEPS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	dep_dir_if.sink     din,
	dep_pix_if.source   dout,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [13:0] cfg_data
);
	import dep_pkg::*;

	localparam int N = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
	localparam int SQ = 25;           // radicand below 2^50
	localparam int SW = 2 * SQ;
	localparam int DEPTH = 1 + SQ + N + 3;
	localparam int AW = ANGLE_BITS;
	localparam logic signed [AW:0] Quarter = (AW + 1)'(1) <<< (AW - 2);
	localparam logic signed [AW:0] Half = (AW + 1)'(1) <<< (AW - 1);

	logic [WidthW-1:0]  width_q;
	logic [HeightW-1:0] height_q;
	logic               adv;
	logic [DEPTH-1:0]   vld_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthW'(4096);
			height_q <= HeightW'(2048);
		end else if (cfg_we) begin
			case (cfg_index)
				RegWidth:  width_q <= cfg_data;
				RegHeight: height_q <= cfg_data[HeightW-1:0];
				default: ;
			endcase
		end
	end

	assign adv = !vld_q[DEPTH-1] || dout.ready;
	assign din.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[DEPTH-2:0], din.valid};
	end

	// stage 1: squares, scaling, backward fold
	logic [SW-1:0]          rad_s1;
	logic signed [VecW-1:0] ya_s1, la_s1, lb_s1;
	side_t                  sd_s1;
	logic signed [31:0]     xx, zz;
	assign xx = din.dir_x * din.dir_x;
	assign zz = din.dir_z * din.dir_z;
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s1 <= {SW'(xx + zz)} << 16;
			ya_s1  <= VecW'(din.dir_y) <<< 8;
			if (din.dir_z[15]) begin
				la_s1 <= -(VecW'(din.dir_z) <<< 8);
				lb_s1 <= -(VecW'(din.dir_x) <<< 8);
			end else begin
				la_s1 <= VecW'(din.dir_z) <<< 8;
				lb_s1 <= VecW'(din.dir_x) <<< 8;
			end
			sd_s1.degen    <= (din.dir_x == '0) && (din.dir_z == '0);
			sd_s1.zero_vec <= (din.dir_x == '0) && (din.dir_z == '0) && (din.dir_y == '0);
			sd_s1.back     <= din.dir_z[15];
			sd_s1.width    <= width_q;
			sd_s1.height   <= height_q;
		end
	end

	// square root chain; longitude and y ride alongside in delay taps
	logic [SW-1:0]          rem_c [SQ+1];
	logic [SW-1:0]          res_c [SQ+1];
	logic signed [VecW-1:0] yd [SQ+1];
	logic signed [VecW-1:0] lad [SQ+1];
	logic signed [VecW-1:0] lbd [SQ+1];
	side_t                  sdd [SQ+1];
	assign rem_c[0] = rad_s1;
	assign res_c[0] = '0;
	assign yd[0] = ya_s1;
	assign lad[0] = la_s1;
	assign lbd[0] = lb_s1;
	assign sdd[0] = sd_s1;
	for (genvar k = 0; k < SQ; k++) begin : g_sq
		dep_sqrt_cell #(.K(SQ - 1 - k), .W(SW)) u_cell (
			.clk(clk), .en(adv), .rem_i(rem_c[k]), .res_i(res_c[k]),
			.rem_q(rem_c[k+1]), .res_q(res_c[k+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				yd[k+1]  <= yd[k];
				lad[k+1] <= lad[k];
				lbd[k+1] <= lbd[k];
				sdd[k+1] <= sdd[k];
			end
		end
	end

	// two CORDIC chains side by side
	logic signed [VecW-1:0] ta [N+1];
	logic signed [VecW-1:0] tb [N+1];
	logic signed [AW:0]     tang [N+1];
	logic signed [VecW-1:0] pa [N+1];
	logic signed [VecW-1:0] pb [N+1];
	logic signed [AW:0]     pang [N+1];
	side_t                  sdc [N+1];
	assign ta[0] = VecW'(res_c[SQ]);
	assign tb[0] = yd[SQ];
	assign tang[0] = '0;
	assign pa[0] = lad[SQ];
	assign pb[0] = lbd[SQ];
	assign pang[0] = '0;
	assign sdc[0] = sdd[SQ];
	for (genvar i = 0; i < N; i++) begin : g_cor
		dep_cordic_cell #(.I(i), .AW(AW), .VW(VecW)) u_lat (
			.clk(clk), .en(adv), .a_i(ta[i]), .b_i(tb[i]), .ang_i(tang[i]),
			.a_q(ta[i+1]), .b_q(tb[i+1]), .ang_q(tang[i+1])
		);
		dep_cordic_cell #(.I(i), .AW(AW), .VW(VecW)) u_lon (
			.clk(clk), .en(adv), .a_i(pa[i]), .b_i(pb[i]), .ang_i(pang[i]),
			.a_q(pa[i+1]), .b_q(pb[i+1]), .ang_q(pang[i+1])
		);
		always_ff @(posedge clk) begin
			if (adv) sdc[i+1] <= sdc[i];
		end
	end

	// stage A: clamp latitude, wrap longitude
	logic signed [AW+1:0] latr;
	logic [AW-1:0]        lat_sa, lon_sa;
	side_t                sd_sa;
	assign latr = (AW + 2)'(Quarter) - (AW + 2)'(tang[N]);
	always_ff @(posedge clk) begin
		if (adv) begin
			if (sdc[N].zero_vec) lat_sa <= AW'(Quarter);
			else if (latr < 0) lat_sa <= '0;
			else if (latr > (AW + 2)'(Half)) lat_sa <= AW'(Half);
			else lat_sa <= AW'(latr);
			lon_sa <= AW'(pang[N] + (sdc[N].back ? Half : '0));
			sd_sa <= sdc[N];
		end
	end

	// stage B: products
	logic [AW+HeightW:0]  rp_sb;
	logic [AW+WidthW-1:0] cp_sb;
	side_t                sd_sb;
	always_ff @(posedge clk) begin
		if (adv) begin
			rp_sb <= (AW + HeightW + 1)'(lat_sa) * (AW + HeightW + 1)'(sd_sa.height)
				* (AW + HeightW + 1)'(2);
			cp_sb <= (AW + WidthW)'(lon_sa) * (AW + WidthW)'(sd_sa.width);
			sd_sb <= sd_sa;
		end
	end

	// stage C: saturate and mirror
	logic [HeightW:0] rq;
	logic [WidthW:0]  cq;
	logic [WidthW:0]  cv;
	logic [RowW-1:0]  row_c;
	logic [ColW-1:0]  col_c;
	assign rq = rp_sb[AW+HeightW:AW];
	assign cq = {1'b0, cp_sb[AW+WidthW-1:AW]};
	assign cv = {1'b0, sd_sb.width} - 1'b1 - cq;
	always_comb begin
		if (sd_sb.height == '0) row_c = '0;
		else if (rq > {1'b0, sd_sb.height} - 1'b1) begin
			if (sd_sb.height > HeightW'(4096)) row_c = '1;
			else row_c = RowW'(sd_sb.height - 1'b1);
		end else if (rq > (HeightW + 1)'(4095)) row_c = '1;
		else row_c = RowW'(rq);
		if (sd_sb.degen || sd_sb.width == '0) col_c = '0;
		else if (cv > (WidthW + 1)'(8191)) col_c = '1;
		else col_c = ColW'(cv);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dout.pixel_row    <= row_c;
			dout.pixel_column <= col_c;
			dout.degenerate   <= sd_sb.degen;
		end
	end
	assign dout.valid = vld_q[DEPTH-1];
endmodule
